// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

// File: sv/mcmh_pkg.sv
// Package: codes, types and constants of the MIDI channel message handler
`default_nettype none
package mcmh_pkg;

   localparam int CHANNEL_COUNT_DEF    = 16;
   localparam int CONTROLLER_COUNT_DEF = 128;

   // Message commands
   localparam logic [2:0] CMD_NOTE_OFF = 3'd0;
   localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
   localparam logic [2:0] CMD_CONTROL  = 3'd2;
   localparam logic [2:0] CMD_BEND     = 3'd3;
   localparam logic [2:0] CMD_PROGRAM  = 3'd4;

   // Event kinds
   localparam logic [2:0] EV_NOTE_ON  = 3'd0;
   localparam logic [2:0] EV_NOTE_OFF = 3'd1;
   localparam logic [2:0] EV_PANIC    = 3'd2;
   localparam logic [2:0] EV_VOLUME   = 3'd3;
   localparam logic [2:0] EV_BEND     = 3'd4;
   localparam logic [2:0] EV_PROGRAM  = 3'd5;

   // Controller numbers
   localparam logic [6:0] CC_DATA_COARSE = 7'd6;
   localparam logic [6:0] CC_VOLUME      = 7'd7;
   localparam logic [6:0] CC_PAN         = 7'd10;
   localparam logic [6:0] CC_NRPN_LSB    = 7'd98;
   localparam logic [6:0] CC_NRPN_MSB    = 7'd99;
   localparam logic [6:0] CC_RPN_LSB     = 7'd100;
   localparam logic [6:0] CC_RPN_MSB     = 7'd101;
   localparam logic [6:0] CC_SOUND_OFF   = 7'd120;
   localparam logic [6:0] CC_RESET_CTRL  = 7'd121;
   localparam logic [6:0] CC_NOTES_OFF   = 7'd123;
   localparam logic [7:0] NRPN_BLOCK     = 8'h3f;

   // Register index (byte address bit 2)
   localparam logic CSR_BEND_RANGE = 1'b0;
   localparam logic [4:0] BEND_RANGE_RESET = 5'd2;

   localparam logic [15:0] UNITY_FACTOR = 16'd8192;
   localparam logic [20:0] BEND_OFFSET  = 21'd294912;
   localparam logic [31:0] LN2_Q30      = 32'h2C5C85FD;
   localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
   localparam logic [3:0]  DIV_THREE    = 4'd3;
   localparam logic [3:0]  TERM_FIRST   = 4'd1;
   localparam logic [3:0]  TERM_LAST    = 4'd12;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_SCALE, ST_SPLIT, ST_FMUL, ST_FFIX, ST_YMUL, ST_YSET,
      ST_TMUL, ST_TSHIFT, ST_DMUL, ST_DFIX, ST_FINAL, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_EXEC, OP_SCALE, OP_SPLIT, OP_DMUL, OP_FFIX, OP_YMUL,
      OP_YSET, OP_TMUL, OP_TSHIFT, OP_TFIX, OP_FINAL
   } op_type;

   typedef struct packed {
      logic bend;
      logic emit;
      logic k_last;
   } status_type;

   // floor((2^32-1)/k), used as reciprocal for the small divisors
   function automatic logic [31:0] recip(input logic [3:0] k);
      logic [31:0] r;
      unique case (k)
         4'd1:    r = 32'hFFFFFFFF;
         4'd2:    r = 32'h7FFFFFFF;
         4'd3:    r = 32'h55555555;
         4'd4:    r = 32'h3FFFFFFF;
         4'd5:    r = 32'h33333333;
         4'd6:    r = 32'h2AAAAAAA;
         4'd7:    r = 32'h24924924;
         4'd8:    r = 32'h1FFFFFFF;
         4'd9:    r = 32'h1C71C71C;
         4'd10:   r = 32'h19999999;
         4'd11:   r = 32'h1745D174;
         4'd12:   r = 32'h15555555;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/mcmh_ctrl.sv
// Controller: sequences decode and the bend factor computation
`default_nettype none
module mcmh_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire mcmh_pkg::status_type status,
   output mcmh_pkg::op_type         op
);
   import mcmh_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            op = OP_EXEC;
            priority if (status.bend) state_in = ST_SCALE;
            else if (status.emit)     state_in = ST_OUT;
            else                      state_in = ST_IDLE;
         end
         ST_SCALE: begin
            op       = OP_SCALE;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            op       = OP_SPLIT;
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            op       = OP_DMUL;
            state_in = ST_FFIX;
         end
         ST_FFIX: begin
            op       = OP_FFIX;
            state_in = ST_YMUL;
         end
         ST_YMUL: begin
            op       = OP_YMUL;
            state_in = ST_YSET;
         end
         ST_YSET: begin
            op       = OP_YSET;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            op       = OP_TMUL;
            state_in = ST_TSHIFT;
         end
         ST_TSHIFT: begin
            op       = OP_TSHIFT;
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            op       = OP_DMUL;
            state_in = ST_DFIX;
         end
         ST_DFIX: begin
            op       = OP_TFIX;
            state_in = status.k_last ? ST_FINAL : ST_TMUL;
         end
         ST_FINAL: begin
            op       = OP_FINAL;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/mcmh_datapath.sv
// Datapath: channel stores, bend factor arithmetic and result registers
`default_nettype none
module mcmh_datapath #(
   parameter int CHANNEL_COUNT = mcmh_pkg::CHANNEL_COUNT_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mcmh_pkg::op_type    op,
   output mcmh_pkg::status_type     status,
   input  wire logic                cfg_we,
   input  wire logic [4:0]          cfg_wdata,
   output logic [4:0]               bend_range,
   input  wire logic [2:0]          req_cmd,
   input  wire logic [3:0]          req_midi_channel,
   input  wire logic [6:0]          req_data_one,
   input  wire logic [6:0]          req_data_two,
   output logic [2:0]               rsp_event_kind,
   output logic [3:0]               rsp_event_channel,
   output logic [6:0]               rsp_note_number,
   output logic [6:0]               rsp_note_velocity,
   output logic [6:0]               rsp_channel_program,
   output logic [15:0]              rsp_bend_factor
);
   import mcmh_pkg::*;

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic [2:0]  cmd_ff;
   logic [3:0]  ch_ff;
   logic [6:0]  d1_ff, d2_ff;
   logic [4:0]  range_ff;
   logic [6:0]  prog_ff [CHANNEL_COUNT];
   logic [15:0] bend_ff [CHANNEL_COUNT];
   logic        vol_nz_ff [CHANNEL_COUNT];
   logic [19:0] m_ff;
   logic [2:0]  q_ff;
   logic [31:0] divx_ff;
   logic [3:0]  divk_ff;
   logic [63:0] prod_ff, prod_in;
   logic [29:0] f_ff, y_ff;
   logic [31:0] term_ff, sum_ff;

   logic [CH_W-1:0] ch_idx;
   logic            ch_ok, is_panic;
   logic [31:0]     mul_a, mul_b;
   logic [31:0]     q0, quot, rem;
   logic [35:0]     qk;
   logic signed [13:0] bend_s;
   logic signed [20:0] n_s;
   logic [4:0]      hi;
   logic [2:0]      q_in;
   logic [4:0]      r_hi;
   logic [36:0]     wide;
   logic [15:0]     factor;

   assign ch_idx   = ch_ff[CH_W-1:0];
   assign ch_ok    = {1'b0, ch_ff} < 5'(CHANNEL_COUNT);
   assign is_panic = (d1_ff == CC_SOUND_OFF) || (d1_ff == CC_RESET_CTRL)
                     || (d1_ff == CC_NOTES_OFF);
   assign bend_range = range_ff;

   assign status.bend   = ch_ok && (cmd_ff == CMD_BEND);
   assign status.emit   = ch_ok && ((cmd_ff == CMD_NOTE_OFF) || (cmd_ff == CMD_NOTE_ON)
                          || (cmd_ff == CMD_PROGRAM)
                          || ((cmd_ff == CMD_CONTROL) && (is_panic
                              || (d1_ff == CC_VOLUME) || (d1_ff == CC_PAN))));
   assign status.k_last = (divk_ff == TERM_LAST);

   // Shared multiplier, one product per cycle
   always_comb begin
      unique case (op)
         OP_YMUL: begin
            mul_a = {2'b0, f_ff};
            mul_b = LN2_Q30;
         end
         OP_TMUL: begin
            mul_a = term_ff;
            mul_b = {2'b0, y_ff};
         end
         default: begin
            mul_a = divx_ff;
            mul_b = recip(divk_ff);
         end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // Reciprocal quotient is exact or one short: correct once
   always_comb begin
      q0   = prod_ff[63:32];
      qk   = 36'(q0) * 36'(divk_ff);
      rem  = divx_ff - qk[31:0];
      quot = (rem >= 32'(divk_ff)) ? q0 + 32'd1 : q0;
   end

   always_comb begin
      bend_s = $signed({~d2_ff[6], d2_ff[5:0], d1_ff});
      n_s    = 21'(bend_s) * $signed({16'b0, range_ff});
      hi     = m_ff[19:15];
      priority if (hi >= 5'd15) q_in = 3'd5;
      else if (hi >= 5'd12)     q_in = 3'd4;
      else if (hi >= 5'd9)      q_in = 3'd3;
      else if (hi >= 5'd6)      q_in = 3'd2;
      else if (hi >= 5'd3)      q_in = 3'd1;
      else                      q_in = 3'd0;
      r_hi   = hi - 5'(q_in) * 5'd3;
      wide   = {5'b0, sum_ff} << q_ff;
      factor = (wide[36:20] > 17'd65535) ? 16'hFFFF : wide[35:20];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= BEND_RANGE_RESET;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            prog_ff[i]   <= '0;
            bend_ff[i]   <= UNITY_FACTOR;
            vol_nz_ff[i] <= 1'b1;
         end
      end else begin
         if (cfg_we) range_ff <= cfg_wdata;
         if (op == OP_EXEC && ch_ok) begin
            unique case (cmd_ff)
               CMD_CONTROL: begin
                  if (is_panic) begin
                     for (int i = 0; i < CHANNEL_COUNT; i++) begin
                        bend_ff[i]   <= UNITY_FACTOR;
                        vol_nz_ff[i] <= 1'b1;
                     end
                  end else if (d1_ff == CC_VOLUME) begin
                     vol_nz_ff[ch_idx] <= (d2_ff != 7'd0);
                  end
               end
               CMD_PROGRAM: prog_ff[ch_idx] <= d1_ff;
               default: ;
            endcase
         end
         if (op == OP_FINAL) bend_ff[ch_idx] <= factor;
      end
   end

   // Payload and arithmetic registers
   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            cmd_ff <= req_cmd;
            ch_ff  <= req_midi_channel;
            d1_ff  <= req_data_one;
            d2_ff  <= req_data_two;
         end
         OP_EXEC: begin
            rsp_event_channel <= ch_ff;
            unique case (cmd_ff)
               CMD_NOTE_ON: begin
                  rsp_note_number <= d1_ff;
                  rsp_bend_factor <= bend_ff[ch_idx];
                  if (d2_ff != 7'd0 && vol_nz_ff[ch_idx]) begin
                     rsp_event_kind      <= EV_NOTE_ON;
                     rsp_note_velocity   <= d2_ff;
                     rsp_channel_program <= prog_ff[ch_idx];
                  end else begin
                     rsp_event_kind      <= EV_NOTE_OFF;
                     rsp_note_velocity   <= '0;
                     rsp_channel_program <= '0;
                  end
               end
               CMD_CONTROL: begin
                  rsp_note_number     <= '0;
                  rsp_note_velocity   <= '0;
                  rsp_channel_program <= '0;
                  if (is_panic) begin
                     rsp_event_kind  <= EV_PANIC;
                     rsp_bend_factor <= UNITY_FACTOR;
                  end else begin
                     rsp_event_kind  <= EV_VOLUME;
                     rsp_bend_factor <= bend_ff[ch_idx];
                  end
               end
               CMD_PROGRAM: begin
                  rsp_event_kind      <= EV_PROGRAM;
                  rsp_note_number     <= '0;
                  rsp_note_velocity   <= '0;
                  rsp_channel_program <= d1_ff;
                  rsp_bend_factor     <= bend_ff[ch_idx];
               end
               default: begin
                  rsp_event_kind      <= EV_NOTE_OFF;
                  rsp_note_number     <= d1_ff;
                  rsp_note_velocity   <= '0;
                  rsp_channel_program <= '0;
                  rsp_bend_factor     <= bend_ff[ch_idx];
               end
            endcase
         end
         OP_SCALE: m_ff <= 20'(n_s + $signed(BEND_OFFSET));
         OP_SPLIT: begin
            q_ff    <= q_in;
            divx_ff <= {r_hi[1:0], m_ff[14:0], 15'b0};
            divk_ff <= DIV_THREE;
         end
         OP_DMUL, OP_YMUL, OP_TMUL: prod_ff <= prod_in;
         OP_FFIX: f_ff <= quot[29:0];
         OP_YSET: begin
            y_ff    <= prod_ff[59:30];
            term_ff <= ONE_Q30;
            sum_ff  <= ONE_Q30;
            divk_ff <= TERM_FIRST;
         end
         OP_TSHIFT: divx_ff <= prod_ff[61:30];
         OP_TFIX: begin
            term_ff <= quot;
            sum_ff  <= sum_ff + quot;
            divk_ff <= divk_ff + 4'd1;
         end
         OP_FINAL: begin
            rsp_event_kind      <= EV_BEND;
            rsp_event_channel   <= ch_ff;
            rsp_note_number     <= '0;
            rsp_note_velocity   <= '0;
            rsp_channel_program <= '0;
            rsp_bend_factor     <= factor;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/midi_channel_message_handler.sv
// Top level: MIDI channel message handler, controller plus datapath
// Usage:
// One decoded channel message (command, channel, two data bytes) enters on
// the req_ channel by valid/ready; at most one event leaves on rsp_.
// Messages on channels at or above CHANNEL_COUNT, unknown commands and
// controllers other than volume, pan and the panic set give no event.
// Sequence: note, controller and program messages go from acceptance through
// the decode state to the output state; a pitch bend also runs the 12-term
// exponential series, term by term, on one shared multiplier.
// No event: the block goes from the decode state straight back to idle.
// One message is in flight at a time; req_ready is low from acceptance until
// the event is taken.
// While the receiver stalls, the event is held stable in the output
// registers and no new transaction is taken.
// Reset (synchronous) restores volume full, bend factor unity and program 0
// on every channel and a bend range of 2 semitones; no clearing pass.
// csr_: one register, bend range at byte address 0; user writes only while idle, unenforced.
`default_nettype none
`include "assert_macros.svh"
module midi_channel_message_handler #(
   parameter int CHANNEL_COUNT = mcmh_pkg::CHANNEL_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [3:0]  req_midi_channel,
   input  wire logic [6:0]  req_data_one,
   input  wire logic [6:0]  req_data_two,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic [3:0]       rsp_event_channel,
   output logic [6:0]       rsp_note_number,
   output logic [6:0]       rsp_note_velocity,
   output logic [6:0]       rsp_channel_program,
   output logic [15:0]      rsp_bend_factor,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mcmh_pkg::*;

   op_type     op;
   status_type status;
   logic       cfg_we;
   logic [4:0] bend_range;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_BEND_RANGE);
   assign csr_prdata = (csr_paddr[2] == CSR_BEND_RANGE) ? {27'b0, bend_range} : 32'b0;

   mcmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   mcmh_datapath #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .status              (status),
      .cfg_we              (cfg_we),
      .cfg_wdata           (csr_pwdata[4:0]),
      .bend_range          (bend_range),
      .req_cmd             (req_cmd),
      .req_midi_channel    (req_midi_channel),
      .req_data_one        (req_data_one),
      .req_data_two        (req_data_two),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_event_channel   (rsp_event_channel),
      .rsp_note_number     (rsp_note_number),
      .rsp_note_velocity   (rsp_note_velocity),
      .rsp_channel_program (rsp_channel_program),
      .rsp_bend_factor     (rsp_bend_factor)
   );

   `ASSERT_IMPLIES(a_one_side, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLIES(a_kind_range, clock, reset, rsp_valid, rsp_event_kind <= EV_PROGRAM)
   `ASSERT_IMPLIES(a_quiet_fields, clock, reset,
      rsp_valid && rsp_event_kind != EV_NOTE_ON, rsp_note_velocity == 7'd0)

endmodule
`default_nettype wire

// File: dv/midi_channel_message_handler_tb.sv
// Testbench for the MIDI channel message handler: directed and random messages against a predictor
`timescale 1ns / 1ps
`default_nettype none
module midi_channel_message_handler_tb;
   import mcmh_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 70;
   localparam int RANDOM_ITEMS   = 450;

   typedef struct {
      logic [2:0]  kind;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [6:0]  prog;
      logic [15:0] factor;
   } midi_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [3:0]  req_midi_channel = '0;
   logic [6:0]  req_data_one = '0;
   logic [6:0]  req_data_two = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [3:0]  rsp_event_channel;
   logic [6:0]  rsp_note_number;
   logic [6:0]  rsp_note_velocity;
   logic [6:0]  rsp_channel_program;
   logic [15:0] rsp_bend_factor;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [7:0]  ctrl_values [16][128];
   logic [6:0]  channel_programs [16];
   logic [15:0] channel_factors [16];
   logic [4:0]  bend_range;

   midi_event_type pending_events [$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off_left = 0;
   int          quiet_cycles = 0;

   midi_channel_message_handler u_top (.*);

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic logic [15:0] bend_multiplier(input logic [6:0] lsb, input logic [6:0] msb,
                                                   input logic [4:0] range);
      longint signed offset;
      longint unsigned m, q, r, f, y, term, sum, res;
      offset = longint'({msb, lsb}) - 8192;
      m = longint'(offset * longint'(range) + 294912);
      q = m / 98304;
      r = m % 98304;
      f = (r * 32768) / 3;
      y = (f * 64'h2C5C85FD) >> 30;
      term = 64'd1 << 30;
      sum = term;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * y) >> 30) / k;
         sum += term;
      end
      res = (sum << q) >> 20;
      if (res > 65535) res = 65535;
      return res[15:0];
   endfunction

   function automatic void reset_channel(input int ch);
      for (int c = 0; c < 128; c++) ctrl_values[ch][c] = '0;
      ctrl_values[ch][CC_VOLUME] = 8'd255;
      channel_factors[ch] = UNITY_FACTOR;
   endfunction

   function automatic void predict_message(input logic [2:0] cmd, input logic [3:0] ch,
                                           input logic [6:0] d1, input logic [6:0] d2);
      midi_event_type ev;
      ev = '{kind: EV_NOTE_OFF, channel: ch, note: '0, velocity: '0, prog: '0, factor: '0};
      unique case (cmd)
         CMD_NOTE_OFF: ev.note = d1;
         CMD_NOTE_ON: begin
            ev.note = d1;
            if (d2 != 0 && ctrl_values[ch][CC_VOLUME] != 0) begin
               ev.kind = EV_NOTE_ON;
               ev.velocity = d2;
               ev.prog = channel_programs[ch];
            end
         end
         CMD_CONTROL: begin
            ctrl_values[ch][d1] = {1'b0, d2};
            if (d1 == CC_SOUND_OFF || d1 == CC_RESET_CTRL || d1 == CC_NOTES_OFF) begin
               for (int i = 0; i < 16; i++) reset_channel(i);
               ev.kind = EV_PANIC;
            end else if (d1 == CC_VOLUME || d1 == CC_PAN) begin
               ev.kind = EV_VOLUME;
            end else begin
               // NRPN select blocks the RPN select bytes
               if (d1 == CC_NRPN_LSB || d1 == CC_NRPN_MSB) begin
                  ctrl_values[ch][CC_RPN_LSB] = NRPN_BLOCK;
                  ctrl_values[ch][CC_RPN_MSB] = NRPN_BLOCK;
               end
               return;
            end
         end
         CMD_BEND: begin
            channel_factors[ch] = bend_multiplier(d1, d2, bend_range);
            ev.kind = EV_BEND;
         end
         CMD_PROGRAM: begin
            channel_programs[ch] = d1;
            ev.prog = d1;
            ev.kind = EV_PROGRAM;
         end
         default: return;
      endcase
      ev.factor = channel_factors[ch];
      pending_events.push_back(ev);
   endfunction

   task automatic send_message(input logic [2:0] cmd, input logic [3:0] ch,
                               input logic [6:0] d1, input logic [6:0] d2);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(8, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_midi_channel <= ch;
      req_data_one <= d1;
      req_data_two <= d2;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_message(cmd, ch, d1, d2);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      // a message with no event may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bend_range(input logic [4:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_BEND_RANGE, 2'b00};
      csr_pwdata <= {27'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      bend_range = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[4:0] !== value) report_mismatch("bend range readback", csr_prdata, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // receiver: check each event, then pick next ready
   always @(posedge clock) begin
      midi_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected event kind", rsp_event_kind, -1);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind) report_mismatch("kind", rsp_event_kind, want.kind);
            if (rsp_event_channel !== want.channel)
               report_mismatch("channel", rsp_event_channel, want.channel);
            if (rsp_note_number !== want.note) report_mismatch("note", rsp_note_number, want.note);
            if (rsp_note_velocity !== want.velocity)
               report_mismatch("velocity", rsp_note_velocity, want.velocity);
            if (rsp_channel_program !== want.prog)
               report_mismatch("program", rsp_channel_program, want.prog);
            if (rsp_bend_factor !== want.factor)
               report_mismatch("bend factor", rsp_bend_factor, want.factor);
         end
      end
      if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_message(CMD_NOTE_ON, 4'd0, 7'd127, 7'd127);
      send_message(CMD_NOTE_ON, 4'd15, 7'd0, 7'd0);
      send_message(CMD_NOTE_OFF, 4'd15, 7'd0, 7'd127);
      send_message(CMD_CONTROL, 4'd3, CC_VOLUME, 7'd0);
      send_message(CMD_NOTE_ON, 4'd3, 7'd60, 7'd100);
      send_message(CMD_CONTROL, 4'd3, CC_VOLUME, 7'd127);
      send_message(CMD_CONTROL, 4'd3, CC_PAN, 7'd64);
      send_message(CMD_CONTROL, 4'd3, CC_NRPN_LSB, 7'd1);
      send_message(CMD_CONTROL, 4'd3, CC_NRPN_MSB, 7'd2);
      send_message(CMD_CONTROL, 4'd3, CC_DATA_COARSE, 7'd12);
      send_message(CMD_CONTROL, 4'd3, 7'd127, 7'd127);
      send_message(CMD_PROGRAM, 4'd5, 7'd127, 7'd0);
      send_message(CMD_NOTE_ON, 4'd5, 7'd64, 7'd1);
      send_message(CMD_BEND, 4'd5, 7'd0, 7'd0);
      send_message(CMD_BEND, 4'd6, 7'd127, 7'd127);
      send_message(CMD_BEND, 4'd7, 7'd0, 7'd64);
      send_message(CMD_CONTROL, 4'd2, CC_SOUND_OFF, 7'd5);
      send_message(CMD_BEND, 4'd8, 7'd33, 7'd90);
      send_message(CMD_CONTROL, 4'd9, CC_RESET_CTRL, 7'd0);
      send_message(CMD_CONTROL, 4'd3, CC_VOLUME, 7'd0);
      send_message(CMD_CONTROL, 4'd9, CC_NOTES_OFF, 7'd127);
      send_message(CMD_NOTE_ON, 4'd3, 7'd1, 7'd1);
      send_message(3'd5, 4'd1, 7'd127, 7'd127);
      send_message(3'd6, 4'd2, 7'd0, 7'd0);
      send_message(3'd7, 4'd4, 7'd85, 7'd42);
   endtask

   task automatic test_bend_ranges();
      logic [4:0] ranges [5] = '{5'd1, 5'd24, 5'd0, 5'd31, 5'd13};
      foreach (ranges[i]) begin
         write_bend_range(ranges[i]);
         send_message(CMD_BEND, 4'($urandom_range(15)), 7'd0, 7'd0);
         send_message(CMD_BEND, 4'($urandom_range(15)), 7'd127, 7'd127);
         repeat (4)
            send_message(CMD_BEND, 4'($urandom_range(15)), 7'($urandom_range(127)),
                         7'($urandom_range(127)));
      end
   endtask

   task automatic send_random_message();
      logic [6:0] controls [10] = '{CC_VOLUME, CC_PAN, CC_NRPN_LSB, CC_NRPN_MSB, CC_RPN_LSB,
                                    CC_RPN_MSB, CC_DATA_COARSE, CC_SOUND_OFF, CC_RESET_CTRL,
                                    CC_NOTES_OFF};
      int pick;
      logic [6:0] d1, d2;
      pick = $urandom_range(99);
      d1 = 7'($urandom_range(127));
      d2 = 7'($urandom_range(127));
      if (pick < 20) begin
         send_message(CMD_NOTE_ON, 4'($urandom_range(15)), d1,
                      ($urandom_range(9) == 0) ? 7'd0 : d2);
      end else if (pick < 35) begin
         send_message(CMD_NOTE_OFF, 4'($urandom_range(15)), d1, d2);
      end else if (pick < 60) begin
         if ($urandom_range(2) == 0) begin
            d1 = controls[$urandom_range(6)];
         end else if ($urandom_range(19) == 0) begin
            d1 = controls[$urandom_range(9, 7)];
         end
         // zero volume now and then so note-on turns into note-off
         if (d1 == CC_VOLUME && $urandom_range(3) == 0) d2 = 7'd0;
         send_message(CMD_CONTROL, 4'($urandom_range(15)), d1, d2);
      end else if (pick < 80) begin
         send_message(CMD_BEND, 4'($urandom_range(15)), d1, d2);
      end else if (pick < 94) begin
         send_message(CMD_PROGRAM, 4'($urandom_range(15)), d1, d2);
      end else begin
         send_message(3'($urandom_range(7, 5)), 4'($urandom_range(15)), d1, d2);
      end
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct, input logic [4:0] range);
      write_bend_range(range);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (RANDOM_ITEMS) send_random_message();
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_off_left = 300;
      repeat (12) send_random_message();
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         reset_channel(i);
         channel_programs[i] = '0;
      end
      bend_range = BEND_RANGE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 19;
      recv_stall_pct = 82;
      test_directed();
      test_bend_ranges();
      test_random(19, 82, 5'd24);
      test_backpressure();
      test_random(82, 19, 5'd1);
      test_random(0, 0, 5'd2);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_events.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: midi_channel_message_handler.f
+incdir+sv
sv/mcmh_pkg.sv
sv/mcmh_ctrl.sv
sv/mcmh_datapath.sv
sv/midi_channel_message_handler.sv
dv/midi_channel_message_handler_tb.sv
